[hw/rtl/writ_pkg.sv]
// Shared types and constants for the work/rest interval timer.
// Used by writ_cfg, writ_core and work_rest_interval_timer; no dependencies.
package writ_pkg;

  // field widths
  localparam int unsigned TimeW   = 17;
  localparam int unsigned CycleW  = 7;
  localparam int unsigned SeriesW = 4;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  // register reset values
  localparam logic [TimeW-1:0]   RstWork    = 17'd5;
  localparam logic [TimeW-1:0]   RstShort   = 17'd3;
  localparam logic [TimeW-1:0]   RstLong    = 17'd5;
  localparam logic [CycleW-1:0]  RstSession = 7'd14;
  localparam logic [SeriesW-1:0] RstSeries  = 4'd4;

  // refill value of seconds and minutes on a borrow
  localparam logic [5:0] SixtyLess1 = 6'd59;

  // register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_WORK    = 3'd0,
    REG_SHORT   = 3'd1,
    REG_LONG    = 3'd2,
    REG_SESSION = 3'd3,
    REG_SERIES  = 3'd4
  } reg_e;

  // item operations
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_RESET    = 3'd1,
    OP_TOGGLE   = 3'd2,
    OP_START    = 3'd3,
    OP_CONTINUE = 3'd4,
    OP_STOP     = 3'd5
  } op_e;

  // configuration as seen by the core
  typedef struct packed {
    logic [TimeW-1:0]   work;
    logic [TimeW-1:0]   short_rest;
    logic [TimeW-1:0]   long_rest;
    logic [CycleW-1:0]  session;
    logic [SeriesW-1:0] series;
  } cfg_t;

  // status after one item
  typedef struct packed {
    logic              phase_ended;
    logic              running;
    logic              in_rest;
    logic [CycleW-1:0] cycles_done;
    logic [TimeW-1:0]  time_left;
  } res_t;

endpackage

[hw/rtl/writ_cfg.sv]
// Configuration register file with an APB-style slave port.
// Depends on writ_pkg for register indexes, widths and reset values.
module writ_cfg import writ_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  reg_e idx;

  assign idx    = reg_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.work       <= RstWork;
      cfg_q.short_rest <= RstShort;
      cfg_q.long_rest  <= RstLong;
      cfg_q.session    <= RstSession;
      cfg_q.series     <= RstSeries;
    end else if (wr_en) begin
      case (idx)
        REG_WORK:    cfg_q.work       <= pwdata[TimeW-1:0];
        REG_SHORT:   cfg_q.short_rest <= pwdata[TimeW-1:0];
        REG_LONG:    cfg_q.long_rest  <= pwdata[TimeW-1:0];
        REG_SESSION: cfg_q.session    <= pwdata[CycleW-1:0];
        REG_SERIES:  cfg_q.series     <= pwdata[SeriesW-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    prdata = '0;
    case (idx)
      REG_WORK:    prdata = {{(DataW-TimeW){1'b0}}, cfg_q.work};
      REG_SHORT:   prdata = {{(DataW-TimeW){1'b0}}, cfg_q.short_rest};
      REG_LONG:    prdata = {{(DataW-TimeW){1'b0}}, cfg_q.long_rest};
      REG_SESSION: prdata = {{(DataW-CycleW){1'b0}}, cfg_q.session};
      REG_SERIES:  prdata = {{(DataW-SeriesW){1'b0}}, cfg_q.series};
      default:     prdata = '0;
    endcase
  end

endmodule

[hw/rtl/writ_core.sv]
// Timer state and its combinational next-state update for one item.
// Depends on writ_pkg for op codes, the configuration struct and the status struct.
module writ_core import writ_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  op_e              op_i,
  input  logic [TimeW-1:0] load_time_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  logic [TimeW-1:0]   time_q, time_d;
  logic               run_q, run_d;
  logic               rest_q, rest_d;
  logic [CycleW-1:0]  cycle_q, cycle_d;
  logic [SeriesW-1:0] pos_q, pos_d;

  logic [4:0]         hrs, hrs_dec;
  logic [5:0]         mins, mins_dec, secs, secs_dec;
  logic [TimeW-1:0]   time_dec;
  logic               is_zero, expire, long_rest, ended, clr;

  // one-second countdown with borrow
  always_comb begin
    hrs      = time_q[16:12];
    mins     = time_q[11:6];
    secs     = time_q[5:0];
    hrs_dec  = hrs;
    mins_dec = mins;
    secs_dec = secs;
    if (secs != 6'd0) begin
      secs_dec = secs - 6'd1;
    end else if (mins != 6'd0) begin
      mins_dec = mins - 6'd1;
      secs_dec = SixtyLess1;
    end else begin
      hrs_dec  = hrs - 5'd1;
      mins_dec = SixtyLess1;
      secs_dec = SixtyLess1;
    end
    time_dec = {hrs_dec, mins_dec, secs_dec};
  end

  assign is_zero   = (time_q == '0);
  assign expire    = is_zero || (time_dec == '0);
  // long rest closes a series
  assign long_rest = ({1'b0, pos_q} + 5'd1) >= {1'b0, cfg_i.series};

  // next state
  always_comb begin
    time_d  = time_q;
    run_d   = run_q;
    rest_d  = rest_q;
    cycle_d = cycle_q;
    pos_d   = pos_q;
    ended   = 1'b0;
    clr     = 1'b0;
    case (op_i)
      OP_TICK: begin
        if (run_q) begin
          if (!is_zero) time_d = time_dec;
          if (expire) begin
            ended  = 1'b1;
            rest_d = !rest_q;
            if (rest_q) begin
              cycle_d = cycle_q + 7'd1;
              pos_d   = long_rest ? '0 : pos_q + 4'd1;
              time_d  = cfg_i.work;
            end else begin
              time_d  = long_rest ? cfg_i.long_rest : cfg_i.short_rest;
            end
            clr = (cycle_d == cfg_i.session);
          end
        end
      end
      OP_RESET:    clr    = 1'b1;
      OP_TOGGLE:   run_d  = !run_q;
      OP_START: begin
        time_d = load_time_i;
        run_d  = 1'b1;
      end
      OP_CONTINUE: run_d  = 1'b1;
      OP_STOP:     run_d  = 1'b0;
      default: ;
    endcase
    // session end or reset op
    if (clr) begin
      time_d  = cfg_i.work;
      cycle_d = '0;
      pos_d   = '0;
      rest_d  = 1'b0;
      run_d   = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= RstWork;
      run_q   <= 1'b0;
      rest_q  <= 1'b0;
      cycle_q <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      time_q  <= time_d;
      run_q   <= run_d;
      rest_q  <= rest_d;
      cycle_q <= cycle_d;
      pos_q   <= pos_d;
    end
  end

  // status after the item
  assign res_o.phase_ended = ended;
  assign res_o.running     = run_d;
  assign res_o.in_rest     = rest_d;
  assign res_o.cycles_done = cycle_d;
  assign res_o.time_left   = time_d;

endmodule

[hw/rtl/work_rest_interval_timer.sv]
// Work/rest interval timer: one status item out for every item in. An item is
// registered on entry; when it advances, the timer state is updated and the status
// lands in an output register at the same edge. Both take one item per cycle, so the
// sustained rate is one item per clock while out_ready_i is held high. Output valid
// rises once the item has passed the input register and then the output register.
// With the output held off, two items are buffered before the input stalls.
// Configuration registers sit at byte addresses 0x00..0x10; the user must write them
// only while no item is in flight, which the block itself does not enforce.
// Depends on writ_pkg, writ_cfg and writ_core.
module work_rest_interval_timer import writ_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       op_i,
  input  logic [TimeW-1:0] load_time_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             phase_ended_o,
  output logic             running_o,
  output logic             in_rest_o,
  output logic [CycleW-1:0] cycles_done_o,
  output logic [TimeW-1:0] time_left_o
);

  cfg_t             cfg;
  res_t             res, res_q;
  logic             in_valid_q, out_valid_q, advance;
  op_e              op_q;
  logic [TimeW-1:0] load_q;

  writ_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item moves into the output register when that is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_e'(op_i);
      load_q <= load_time_i;
    end
  end

  writ_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .op_i        (op_q),
    .load_time_i (load_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phase_ended_o = res_q.phase_ended;
  assign running_o     = res_q.running;
  assign in_rest_o     = res_q.in_rest;
  assign cycles_done_o = res_q.cycles_done;
  assign time_left_o   = res_q.time_left;

`ifndef SYNTHESIS
  // reset op leaves a stopped, cleared session
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q == OP_RESET |=> !res_q.running && res_q.cycles_done == '0
      && !res_q.in_rest)
    else $error("reset op did not clear the session");

  // only a tick can end a phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q != OP_TICK |=> !res_q.phase_ended)
    else $error("phase ended on a non-tick item");

  // stop op always stops the timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q == OP_STOP |=> !res_q.running)
    else $error("stop op left the timer running");

  // a held item in the input register is not lost while the output stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("stalled item dropped from input register");
`endif

endmodule
